// File: design/eaf_pkg.sv
// Shared constants, types and angle tables for the elliptical arc flattener.
`timescale 1ns / 1ps
`default_nettype none

package eaf_pkg;

  // Points per arc are SEGMENTS+1, plus the center for pie closure.
  localparam int unsigned SEGMENTS     = 48;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned POINT_W      = 26;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [IDX_W-1:0] IDX_LAST_ARC = IDX_W'(SEGMENTS);
  localparam logic [IDX_W-1:0] IDX_CENTER   = IDX_W'(SEGMENTS + 1);

  // The sweep step divides by SEGMENTS = 16 * 3: a shift by four, then a
  // multiply by the reciprocal of three.
  localparam int unsigned DIV_SHIFT = 4;
  localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
  localparam logic [5:0]  REM_INIT  = 6'(SEGMENTS / 2);
  localparam logic [6:0]  REM_WRAP  = 7'(SEGMENTS);

  localparam logic [31:0] ANG_HALF_TURN = 32'h8000_0000;
  localparam logic [32:0] CORDIC_K      = 33'h0_26DD_3B6A;

  localparam logic [2:0] CLOSE_PIE = 3'd2;

  typedef enum logic {
    REG_MIRROR_X = 1'b0,
    REG_MIRROR_Y = 1'b1
  } reg_idx_t;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  function automatic logic [31:0] atan_step(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    v = '0;
    if (int'(i) < CORDIC_STEPS) v = ATAN_TAB[i];
    return v;
  endfunction

  // Radius basis and one delimiting ray: solve ray = A*cos t + B*sin t.
  typedef struct packed {
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] c;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
  } ang_in_t;

endpackage

`default_nettype wire

// File: design/elliptical_arc_flattener.sv
// Top level of the elliptical arc flattener: arc setup, point sequencer and sin/cos pipeline.
`timescale 1ns / 1ps
`default_nettype none

// The block turns one elliptical arc, given as a center and two conjugate radius
// vectors plus a start and an end ray, into a run of points on the arc.
// One input transaction carries one arc; the result channel carries one point per
// transaction, SEGMENTS+1 points per arc, plus the center as a final point when
// pie closure is selected. tlast marks the final point of each arc.
// The configuration channel is always ready and sets per-axis mirroring; the user
// must write it only while the block is idle, which the block does not enforce.
// An arc first passes two parallel iterative angle units (determinant and ray
// products, normalization, 30 CORDIC steps each; a singular basis or a null ray
// skips normalization and CORDIC), then F_DIV1 and F_DIV2 form the sweep step.
// Its points then leave the sequencer at one per cycle unless the receiver stalls,
// and pass a 35 stage pipeline (issue register, quadrant fold, 30 CORDIC rotation
// stages, products, sum, output register). The setup of the next arc overlaps the
// point run of the current one, so the sustained rate is set by the point rate of
// the result channel.
// Reset clears all valid bits, the sequencer and the mirror settings. When the
// receiver stalls, the whole point pipeline and the sequencer hold in place;
// nothing is dropped or repeated, and one finished arc setup waits meanwhile.

module elliptical_arc_flattener (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // center_x, center_y, radius_a_x, radius_a_y, radius_b_x, radius_b_y,
  // start_ray_x, start_ray_y, end_ray_x, end_ray_y (16 bits each)
  input  logic [eaf_pkg::IN_DATA_W-1:0]     in_tdata,
  // clockwise (bit 0), close_mode (bits 2:1)
  input  logic [eaf_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // point_x (bits 25:0), point_y (bits 51:26), point_index (bits 57:52), zero pad
  output logic [eaf_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic                              cfg_data
);
  import eaf_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_ANG, F_DIV1, F_DIV2, F_HOLD} f_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic                      cw;
    logic                      pie;
  } arc_t;

  // One point travelling down the pipeline with the arc data it needs.
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic [IDX_W-1:0]          idx;
    logic                      last;
    logic                      center;
  } pt_t;

  typedef struct packed {
    pt_t                pt;
    logic               flip;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } cs_t;

  typedef struct packed {
    pt_t                pt;
    logic signed [48:0] pax;
    logic signed [48:0] pbx;
    logic signed [48:0] pay;
    logic signed [48:0] pby;
  } mul_t;

  typedef struct packed {
    pt_t                pt;
    logic signed [49:0] sx;
    logic signed [49:0] sy;
  } sum_t;

  localparam logic signed [49:0] ROUND_HALF = 50'sd2097152;

  // ---------------------------------------------------------------------------
  // Configuration.
  // ---------------------------------------------------------------------------
  logic mirror_x_r, mirror_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_x_r <= 1'b0;
      mirror_y_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MIRROR_X: mirror_x_r <= cfg_data;
        REG_MIRROR_Y: mirror_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Arc setup: both rays are solved in parallel, then the sweep magnitude is
  // split into a per-point quotient and remainder of the division by SEGMENTS.
  // ---------------------------------------------------------------------------
  f_state_t      f_state_r;
  arc_t          arc_r;
  logic [31:0]   t0_r;
  logic [31:0]   mag_r;
  logic [59:0]   prod_r;
  logic [26:0]   qm_r;
  logic [5:0]    rm_r;

  logic          in_accept;
  ang_in_t       start_arg, end_arg;
  logic          start_done, end_done, ang_ack;
  logic [31:0]   start_ang, end_ang, diff;
  logic [26:0]   q3;
  logic [27:0]   r3;
  logic          gen_load;

  assign in_tready = (f_state_r == F_IDLE);
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    start_arg.a  = in_tdata[47:32];
    start_arg.c  = in_tdata[63:48];
    start_arg.b  = in_tdata[79:64];
    start_arg.d  = in_tdata[95:80];
    start_arg.rx = in_tdata[111:96];
    start_arg.ry = in_tdata[127:112];
    end_arg      = start_arg;
    end_arg.rx   = in_tdata[143:128];
    end_arg.ry   = in_tdata[159:144];
  end

  eaf_angle u_ang_start (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_accept),
    .ack   (ang_ack),
    .arg   (start_arg),
    .done  (start_done),
    .angle (start_ang)
  );

  eaf_angle u_ang_end (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_accept),
    .ack   (ang_ack),
    .arg   (end_arg),
    .done  (end_done),
    .angle (end_ang)
  );

  assign ang_ack = (f_state_r == F_ANG) && start_done && end_done;
  assign diff    = end_ang - start_ang;

  // Exact floor division by three for operands below 2^32.
  assign q3 = prod_r[59:33];
  assign r3 = mag_r[31:DIV_SHIFT] - (28'(q3) + (28'(q3) << 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_state_r <= F_IDLE;
    end else begin
      unique case (f_state_r)
        F_IDLE: begin
          if (in_accept) begin
            arc_r.cx  <= in_tdata[15:0];
            arc_r.cy  <= in_tdata[31:16];
            arc_r.ax  <= in_tdata[47:32];
            arc_r.ay  <= in_tdata[63:48];
            arc_r.bx  <= in_tdata[79:64];
            arc_r.by  <= in_tdata[95:80];
            arc_r.cw  <= in_tuser[0];
            arc_r.pie <= ({1'b0, in_tuser[2:1]} == CLOSE_PIE);
            f_state_r <= F_ANG;
          end
        end
        F_ANG: begin
          if (ang_ack) begin
            t0_r      <= start_ang;
            // A clockwise sweep runs over the complement of the turn.
            mag_r     <= arc_r.cw ? (32'd0 - diff) : diff;
            f_state_r <= F_DIV1;
          end
        end
        F_DIV1: begin
          prod_r    <= 60'(mag_r[31:DIV_SHIFT]) * 60'(RECIP3);
          f_state_r <= F_DIV2;
        end
        F_DIV2: begin
          qm_r      <= q3;
          rm_r      <= {r3[1:0], mag_r[DIV_SHIFT-1:0]};
          f_state_r <= F_HOLD;
        end
        F_HOLD: begin
          if (gen_load) f_state_r <= F_IDLE;
        end
        default: f_state_r <= F_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Point sequencer. The angle offset of point k is round(mag*k/SEGMENTS), kept
  // as a running quotient and remainder so no divider is needed per point.
  // ---------------------------------------------------------------------------
  logic              en;
  logic              gen_busy_r;
  logic [IDX_W-1:0]  gen_k_r;
  logic [31:0]       gen_q_r;
  logic [5:0]        gen_r_r;
  arc_t              g_arc_r;
  logic [31:0]       g_t0_r;
  logic [26:0]       g_qm_r;
  logic [5:0]        g_rm_r;

  logic [IDX_W-1:0]  gen_kmax;
  logic              gen_fin;
  logic [6:0]        rsum;
  logic              rwrap;
  logic [31:0]       gen_q_nxt;
  logic [5:0]        gen_r_nxt;
  logic [31:0]       t_issue;
  pt_t               pt_issue;

  assign gen_kmax = g_arc_r.pie ? IDX_CENTER : IDX_LAST_ARC;
  assign gen_fin  = gen_busy_r && en && (gen_k_r == gen_kmax);
  assign gen_load = (f_state_r == F_HOLD) && (!gen_busy_r || gen_fin);

  always_comb begin
    rsum      = 7'(gen_r_r) + 7'(g_rm_r);
    rwrap     = (rsum >= REM_WRAP);
    gen_q_nxt = gen_q_r + 32'(g_qm_r) + 32'(rwrap);
    gen_r_nxt = rwrap ? 6'(rsum - REM_WRAP) : 6'(rsum);
    t_issue   = g_arc_r.cw ? (g_t0_r - gen_q_r) : (g_t0_r + gen_q_r);
    pt_issue.cx     = g_arc_r.cx;
    pt_issue.cy     = g_arc_r.cy;
    pt_issue.ax     = g_arc_r.ax;
    pt_issue.ay     = g_arc_r.ay;
    pt_issue.bx     = g_arc_r.bx;
    pt_issue.by     = g_arc_r.by;
    pt_issue.idx    = gen_k_r;
    pt_issue.last   = (gen_k_r == gen_kmax);
    pt_issue.center = (gen_k_r == IDX_CENTER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_busy_r <= 1'b0;
    end else if (gen_load) begin
      gen_busy_r <= 1'b1;
      gen_k_r    <= '0;
      gen_q_r    <= '0;
      gen_r_r    <= REM_INIT;
      g_arc_r    <= arc_r;
      g_t0_r     <= t0_r;
      g_qm_r     <= qm_r;
      g_rm_r     <= rm_r;
    end else if (gen_fin) begin
      gen_busy_r <= 1'b0;
    end else if (gen_busy_r && en) begin
      gen_k_r <= gen_k_r + 1'b1;
      gen_q_r <= gen_q_nxt;
      gen_r_r <= gen_r_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Point pipeline. Every stage moves together when the output register can
  // take a new point.
  // ---------------------------------------------------------------------------
  logic        out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic        out_tlast_r;

  assign en = !out_tvalid_r || out_tready;

  // Issue register.
  logic        s0_v_r;
  pt_t         s0_pt_r;
  logic [31:0] s0_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r   <= gen_busy_r;
      s0_pt_r  <= pt_issue;
      s0_ang_r <= t_issue;
    end
  end

  // Rotation CORDIC works in [-pi/2, pi/2]; other angles are moved by pi and
  // the result negated at the end.
  cs_t               cs_r   [CORDIC_STEPS+1];
  cs_t               cs_nxt [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] cs_v_r;
  logic signed [32:0] z_wide;

  always_comb begin
    z_wide          = $signed({s0_ang_r[31], s0_ang_r});
    cs_nxt[0].pt    = s0_pt_r;
    cs_nxt[0].x     = $signed(CORDIC_K);
    cs_nxt[0].y     = '0;
    cs_nxt[0].flip  = 1'b0;
    cs_nxt[0].z     = z_wide;
    if (z_wide > 33'sh0_4000_0000) begin
      cs_nxt[0].z    = z_wide - 33'sh0_8000_0000;
      cs_nxt[0].flip = 1'b1;
    end else if (z_wide < -33'sh0_4000_0000) begin
      cs_nxt[0].z    = z_wide + 33'sh0_8000_0000;
      cs_nxt[0].flip = 1'b1;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    logic signed [32:0] tab_s;

    always_comb begin
      tab_s          = $signed({1'b0, ATAN_TAB[g]});
      cs_nxt[g+1]    = cs_r[g];
      if (cs_r[g].z >= 33'sd0) begin
        cs_nxt[g+1].x = cs_r[g].x - (cs_r[g].y >>> g);
        cs_nxt[g+1].y = cs_r[g].y + (cs_r[g].x >>> g);
        cs_nxt[g+1].z = cs_r[g].z - tab_s;
      end else begin
        cs_nxt[g+1].x = cs_r[g].x + (cs_r[g].y >>> g);
        cs_nxt[g+1].y = cs_r[g].y - (cs_r[g].x >>> g);
        cs_nxt[g+1].z = cs_r[g].z + tab_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_v_r <= '0;
    end else if (en) begin
      cs_v_r <= {cs_v_r[CORDIC_STEPS-1:0], s0_v_r};
    end
  end

  for (genvar g = 0; g <= CORDIC_STEPS; g++) begin : g_cs_reg
    always_ff @(posedge clk) begin
      if (en) cs_r[g] <= cs_nxt[g];
    end
  end

  // Products of the radius components with cos and sin.
  logic               mul_v_r;
  mul_t               mul_r;
  logic signed [32:0] cos_v, sin_v;

  always_comb begin
    cos_v = cs_r[CORDIC_STEPS].flip ? -cs_r[CORDIC_STEPS].x : cs_r[CORDIC_STEPS].x;
    sin_v = cs_r[CORDIC_STEPS].flip ? -cs_r[CORDIC_STEPS].y : cs_r[CORDIC_STEPS].y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (en) begin
      mul_v_r   <= cs_v_r[CORDIC_STEPS];
      mul_r.pt  <= cs_r[CORDIC_STEPS].pt;
      mul_r.pax <= 49'(cs_r[CORDIC_STEPS].pt.ax) * 49'(cos_v);
      mul_r.pbx <= 49'(cs_r[CORDIC_STEPS].pt.bx) * 49'(sin_v);
      mul_r.pay <= 49'(cs_r[CORDIC_STEPS].pt.ay) * 49'(cos_v);
      mul_r.pby <= 49'(cs_r[CORDIC_STEPS].pt.by) * 49'(sin_v);
    end
  end

  // Sums with the rounding half of the Q30 to Q8 scaling.
  logic sum_v_r;
  sum_t sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
    end else if (en) begin
      sum_v_r  <= mul_v_r;
      sum_r.pt <= mul_r.pt;
      sum_r.sx <= 50'(mul_r.pax) + 50'(mul_r.pbx) + ROUND_HALF;
      sum_r.sy <= 50'(mul_r.pay) + 50'(mul_r.pby) + ROUND_HALF;
    end
  end

  // Output register: center offset, mirroring and packing.
  logic signed [27:0] cx_q8, cy_q8, px, py;

  always_comb begin
    cx_q8 = 28'(sum_r.pt.cx) <<< 8;
    cy_q8 = 28'(sum_r.pt.cy) <<< 8;
    px    = sum_r.pt.center ? cx_q8 : (cx_q8 + $signed(sum_r.sx[49:22]));
    py    = sum_r.pt.center ? cy_q8 : (cy_q8 + $signed(sum_r.sy[49:22]));
    if (mirror_x_r) px = -px;
    if (mirror_y_r) py = -py;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= sum_v_r;
      out_tdata_r  <= {6'd0, sum_r.pt.idx, py[POINT_W-1:0], px[POINT_W-1:0]};
      out_tlast_r  <= sum_r.pt.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    gen_busy_r |-> (gen_r_r < REM_WRAP[5:0]))
    else $error("sweep remainder out of range");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    gen_busy_r |-> (gen_k_r <= gen_kmax))
    else $error("point counter passed the end of the arc");

  a_ang_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!start_done && !end_done))
    else $error("angle unit still holds a result while a new arc is taken");

  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    gen_load |=> (gen_busy_r && gen_k_r == '0))
    else $error("sequencer did not start a loaded arc at point zero");

endmodule

`default_nettype wire

// File: design/eaf_angle.sv
// Iterative ray-to-angle solver: 2x2 inverse, normalization and CORDIC atan2.
`timescale 1ns / 1ps
`default_nettype none

module eaf_angle (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             ack,
  input  eaf_pkg::ang_in_t arg,
  output logic             done,
  output logic [31:0]      angle
);
  import eaf_pkg::*;

  localparam int unsigned XW = 46;
  localparam logic signed [XW-1:0] NORM_COARSE = XW'(64'd1 << 33);
  localparam logic signed [XW-1:0] NORM_FINE   = XW'(64'd1 << 40);

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_FOLD, A_NORM, A_ROT, A_DONE} a_state_t;

  a_state_t              state_r;
  ang_in_t               arg_r;
  logic                  det_zero_r;
  logic                  det_neg_r;
  logic signed [33:0]    nc_r;
  logic signed [33:0]    ns_r;
  logic signed [XW-1:0]  x_r;
  logic signed [XW-1:0]  y_r;
  logic [31:0]           z_r;
  logic [STEP_W-1:0]     i_r;

  logic signed [31:0]    p_ad, p_bc, p_drx, p_bry, p_ary, p_crx;
  logic signed [32:0]    det;
  logic signed [33:0]    nc, ns;
  logic                  nc_neg, swap;
  logic signed [33:0]    xf, yf;
  logic signed [XW-1:0]  ay, m, xs, ys;
  logic [31:0]           tab;

  always_comb begin
    p_ad  = arg_r.a * arg_r.d;
    p_bc  = arg_r.b * arg_r.c;
    p_drx = arg_r.d * arg_r.rx;
    p_bry = arg_r.b * arg_r.ry;
    p_ary = arg_r.a * arg_r.ry;
    p_crx = arg_r.c * arg_r.rx;
    det   = 33'(p_ad) - 33'(p_bc);
    nc    = 34'(p_drx) - 34'(p_bry);
    ns    = 34'(p_ary) - 34'(p_crx);
  end

  // Undo a negative determinant and fold the left half plane in one negation.
  always_comb begin
    nc_neg = det_neg_r ? (nc_r > 34'sd0) : (nc_r < 34'sd0);
    swap   = det_neg_r ^ nc_neg;
    xf     = swap ? -nc_r : nc_r;
    yf     = swap ? -ns_r : ns_r;
  end

  always_comb begin
    ay  = y_r[XW-1] ? -y_r : y_r;
    m   = (x_r > ay) ? x_r : ay;
    xs  = x_r >>> i_r;
    ys  = y_r >>> i_r;
    tab = atan_step(i_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      unique case (state_r)
        A_IDLE: begin
          if (start) begin
            arg_r   <= arg;
            state_r <= A_MUL;
          end
        end
        A_MUL: begin
          det_zero_r <= (det == 33'sd0);
          det_neg_r  <= det[32];
          nc_r       <= nc;
          ns_r       <= ns;
          state_r    <= A_FOLD;
        end
        A_FOLD: begin
          if (det_zero_r || (nc_r == 34'sd0 && ns_r == 34'sd0)) begin
            z_r     <= '0;
            state_r <= A_DONE;
          end else begin
            x_r     <= XW'(xf);
            y_r     <= XW'(yf);
            z_r     <= nc_neg ? ANG_HALF_TURN : '0;
            state_r <= A_NORM;
          end
        end
        A_NORM: begin
          if (m < NORM_COARSE) begin
            x_r <= x_r <<< 8;
            y_r <= y_r <<< 8;
          end else if (m < NORM_FINE) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            i_r     <= '0;
            state_r <= A_ROT;
          end
        end
        A_ROT: begin
          if (!y_r[XW-1] && (y_r != '0)) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + tab;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - tab;
          end
          i_r <= i_r + 1'b1;
          if (int'(i_r) == CORDIC_STEPS - 1) state_r <= A_DONE;
        end
        A_DONE: begin
          if (ack) state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign done  = (state_r == A_DONE);
  assign angle = z_r;

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the elliptical arc flattener: directed and random arcs.
`timescale 1ns / 1ps

// One arc as it travels on the input channel.
typedef struct {
  logic signed [15:0] cx, cy, ax, ay, bx, by, sx, sy, ex, ey;
  logic               cw;
  logic [1:0]         close_mode;
} arc_t;

// One flattened point as it leaves the block.
typedef struct {
  logic [25:0] px, py;
  logic [5:0]  idx;
  logic        last;
} point_t;

// The point scoreboard predicts the points of each arc and checks the output stream.
class arc_points_sb;
  localparam int STEPS = 30;
  localparam int SEG = eaf_pkg::SEGMENTS;
  point_t      pending[$];
  bit          flip_x, flip_y;
  int          errors;
  logic [31:0] atan_lut [STEPS];

  function new();
    for (int i = 0; i < STEPS; i++) atan_lut[i] = eaf_pkg::ATAN_TAB[i];
    errors = 0;
  endfunction

  // Arithmetic right shift; >>> on a signed 64-bit value floors as needed.
  function longint sra(longint v, int k);
    return v >>> k;
  endfunction

  function logic [31:0] vec_angle(longint x, longint y);
    logic [31:0] z;
    longint      m, ax, ay, xn, yn;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    ax = x;
    ay = (y < 0) ? -y : y;
    m = (ax > ay) ? ax : ay;
    while (m < (64'sd1 <<< 40)) begin
      m = m <<< 1; x = x <<< 1; y = y <<< 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        xn = x + sra(y, i); yn = y - sra(x, i); z = z + atan_lut[i];
      end else begin
        xn = x - sra(y, i); yn = y + sra(x, i); z = z - atan_lut[i];
      end
      x = xn; y = yn;
    end
    return z;
  endfunction

  function void rotate(logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, xn, yn;
    bit     neg;
    z = ang; x = 64'h26DD3B6A; y = 0; neg = 0;
    if (ang[31]) z = z - 64'sh1_0000_0000;
    if (z > 64'sh4000_0000) begin
      z = z - 64'sh8000_0000; neg = 1;
    end else if (z < -64'sh4000_0000) begin
      z = z + 64'sh8000_0000; neg = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        xn = x - sra(y, i); yn = y + sra(x, i); z = z - longint'(atan_lut[i]);
      end else begin
        xn = x + sra(y, i); yn = y - sra(x, i); z = z + longint'(atan_lut[i]);
      end
      x = xn; y = yn;
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = x; s = y;
  endfunction

  // Parameter angle of a ray in the A/B basis; singular basis or null ray give zero.
  function logic [31:0] ray_angle(longint a, longint c, longint b, longint d,
                                  longint rx, longint ry);
    longint det, nc, ns;
    det = a * d - b * c;
    if (det == 0) return 0;
    nc = d * rx - b * ry;
    ns = a * ry - c * rx;
    if (det < 0) begin
      nc = -nc; ns = -ns;
    end
    if (nc == 0 && ns == 0) return 0;
    return vec_angle(nc, ns);
  endfunction

  function void add_point(longint px, longint py, int k, bit last);
    point_t p;
    if (flip_x) px = -px;
    if (flip_y) py = -py;
    p.px = px[25:0]; p.py = py[25:0]; p.idx = k[5:0]; p.last = last;
    pending = {pending, p};
  endfunction

  // Called for every arc the block accepts.
  function void note_arc(arc_t a);
    logic [31:0] t0, t1, diff, t;
    longint      mag, q, c, s, px, py;
    bit          pie;
    pie = (a.close_mode == eaf_pkg::CLOSE_PIE[1:0]);
    t0 = ray_angle(a.ax, a.ay, a.bx, a.by, a.sx, a.sy);
    t1 = ray_angle(a.ax, a.ay, a.bx, a.by, a.ex, a.ey);
    diff = t1 - t0;
    if (a.cw) mag = (diff != 0) ? (64'h1_0000_0000 - longint'(diff)) : 0;
    else mag = diff;
    for (int k = 0; k <= SEG; k++) begin
      q = (mag * k + SEG / 2) / SEG;
      t = a.cw ? t0 - q[31:0] : t0 + q[31:0];
      rotate(t, c, s);
      px = longint'(a.cx) * 256 + sra(longint'(a.ax) * c + longint'(a.bx) * s + (1 << 21), 22);
      py = longint'(a.cy) * 256 + sra(longint'(a.ay) * c + longint'(a.by) * s + (1 << 21), 22);
      add_point(px, py, k, !pie && k == SEG);
    end
    if (pie) add_point(longint'(a.cx) * 256, longint'(a.cy) * 256, SEG + 1, 1);
  endfunction

  // Called for every point the block delivers.
  function void check_point(point_t got);
    point_t exp_p;
    if (pending.size() == 0) begin
      $display("%0t: unexpected point x=%h y=%h idx=%0d last=%0b", $time,
               got.px, got.py, got.idx, got.last);
      errors++;
      return;
    end
    exp_p = pending.pop_front();
    if (got.px !== exp_p.px) begin
      $display("%0t: point_x expected %h actual %h", $time, exp_p.px, got.px); errors++;
    end
    if (got.py !== exp_p.py) begin
      $display("%0t: point_y expected %h actual %h", $time, exp_p.py, got.py); errors++;
    end
    if (got.idx !== exp_p.idx) begin
      $display("%0t: point_index expected %0d actual %0d", $time, exp_p.idx, got.idx);
      errors++;
    end
    if (got.last !== exp_p.last) begin
      $display("%0t: last_point expected %0b actual %0b", $time, exp_p.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb;
  import eaf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                  clk, rst_n;
  logic                  in_tvalid, in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid, cfg_ready, cfg_index, cfg_data;

  arc_points_sb points_sb;
  int           idle_cycles;

  elliptical_arc_flattener dut (.*);

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Receiver: random stall per point, sampled at the rising edge.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 8);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      point_t p;
      p.px = out_tdata[25:0];
      p.py = out_tdata[51:26];
      p.idx = out_tdata[57:52];
      p.last = out_tlast;
      points_sb.check_point(p);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("elliptical_arc_flattener: mismatch");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MIRROR_X) points_sb.flip_x = val;
    else points_sb.flip_y = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends one arc; when gaps is set, the idle gap before it is drawn at random.
  task automatic send_arc(arc_t a, bit gaps);
    int gap;
    gap = gaps ? int'($urandom_range(0, 8)) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {a.ey, a.ex, a.sy, a.sx, a.by, a.bx, a.ay, a.ax, a.cy, a.cx};
    in_tuser <= {a.close_mode, a.cw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    points_sb.note_arc(a);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (points_sb.pending.size() != 0) @(posedge clk);
    // The block has no arc without points, but allow the pipeline to settle.
    while (guard < 100) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic arc_t rnd_arc();
    arc_t a;
    a.cx = rnd_coord(); a.cy = rnd_coord();
    a.ax = rnd_coord(); a.ay = rnd_coord();
    a.bx = rnd_coord(); a.by = rnd_coord();
    a.sx = rnd_coord(); a.sy = rnd_coord();
    a.ex = rnd_coord(); a.ey = rnd_coord();
    a.cw = 1'($urandom_range(0, 1));
    a.close_mode = 2'($urandom_range(0, 3));
    // Occasionally make the basis singular or the rays degenerate.
    case ($urandom_range(0, 15))
      0: begin a.bx = a.ax; a.by = a.ay; end
      1: begin a.sx = '0; a.sy = '0; end
      2: begin a.ex = a.sx; a.ey = a.sy; end
      default: ;
    endcase
    return a;
  endfunction

  function automatic arc_t mk_arc(int cx, int cy, int ax, int ay, int bx, int by,
                                  int sx, int sy, int ex, int ey, bit cw, int cm);
    arc_t a;
    a.cx = 16'(cx); a.cy = 16'(cy); a.ax = 16'(ax); a.ay = 16'(ay);
    a.bx = 16'(bx); a.by = 16'(by);
    a.sx = 16'(sx); a.sy = 16'(sy); a.ex = 16'(ex); a.ey = 16'(ey);
    a.cw = cw; a.close_mode = 2'(cm);
    return a;
  endfunction

  initial begin
    points_sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = 1'b0;
    idle_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed arcs: circle arcs between quarter rays, a skewed ellipse, both directions, every closure mode.
    send_arc(mk_arc(0, 0, 1000, 0, 0, 1000, 1, 0, 0, 1, 0, 0), 0);
    send_arc(mk_arc(0, 0, 1000, 0, 0, 1000, 1, 0, 0, 1, 1, 1), 0);
    send_arc(mk_arc(10, -10, 1000, 0, 0, 1000, 1, 0, 0, 1, 0, 2), 0);
    send_arc(mk_arc(5, 5, 300, 40, -20, 200, 1, 1, 1, 1, 1, 3), 0);
    // Extreme fields.
    send_arc(mk_arc(32767, 32767, 32767, 32767, -32768, 32767,
                    -32768, -32768, 32767, -32768, 1, 2), 0);
    send_arc(mk_arc(-32768, -32768, -32768, -32768, 32767, -32768,
                    32767, 32767, -32768, 32767, 0, 0), 1);
    send_arc(mk_arc(-1, -1, -32768, 0, 0, -32768, -1, -1, -1, 1, 0, 1), 1);
    // Singular basis, zero rays, negative determinant.
    send_arc(mk_arc(1, 2, 100, 100, 200, 200, 5, 7, -3, 9, 0, 0), 1);
    send_arc(mk_arc(1, 2, 100, 0, 0, 100, 0, 0, 0, 0, 1, 2), 1);
    send_arc(mk_arc(0, 0, 0, 100, 100, 0, 3, 4, -4, 3, 0, 0), 1);
    drain();

    write_reg(REG_MIRROR_X, 1'b1);
    send_arc(mk_arc(100, -200, 500, 0, 0, 300, 1, 0, -1, 0, 0, 2), 1);
    drain();
    write_reg(REG_MIRROR_Y, 1'b1);
    send_arc(mk_arc(-32768, 32767, 700, 50, -30, 400, 0, 1, 1, 0, 1, 0), 1);
    drain();

    // Random arcs in four phases with different mirror settings.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_MIRROR_X, ph[0]);
      write_reg(REG_MIRROR_Y, ph[1]);
      for (int n = 0; n < 100; n++) send_arc(rnd_arc(), (ph != 2) && $urandom_range(0, 1));
      drain();
    end

    if (points_sb.errors == 0 && points_sb.pending.size() == 0) begin
      $display("elliptical_arc_flattener: match");
    end else begin
      $display("elliptical_arc_flattener: mismatch");
    end
    $finish;
  end
endmodule
